>>> rtl/pcc_pkg.sv
`default_nettype none

package pcc_pkg;

   // Widths of the region-zero counters, sized for the largest region supported.
   localparam int unsigned PRINT_W = 7;
   localparam int unsigned PTR_W   = 4;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_ASCII_PERCENT_MIN = 2'd0,
      CSR_POINTER_WORDS_MIN = 2'd1,
      CSR_THRASH_LIMIT_NS   = 2'd2
   } pcc_csr_index_type;

   // Page classes in priority order.
   typedef enum logic [2:0] {
      CLASS_ZERO    = 3'd0,
      CLASS_SAME    = 3'd1,
      CLASS_TEXT    = 3'd2,
      CLASS_CODE    = 3'd3,
      CLASS_POINTER = 3'd4,
      CLASS_BINARY  = 3'd5
   } pcc_class_type;

   localparam int unsigned CLASS_NUM = 6;

   // Summary of one complete page event, handed from the front to the back.
   typedef struct packed {
      logic               zero_page;
      logic               same_page;
      logic [7:0]         fill;
      logic [PRINT_W-1:0] printable;
      logic               prologue;
      logic [PTR_W-1:0]   pointers;
      logic [63:0]        interval;
   } pcc_event_type;

   // Configuration values used by the back end.
   typedef struct packed {
      logic [6:0]  ascii_percent_min;
      logic [2:0]  pointer_words_min;
      logic [63:0] thrash_limit_ns;
   } pcc_cfg_type;

endpackage

`default_nettype wire

>>> rtl/pcc_front.sv
`default_nettype none

module pcc_front import pcc_pkg::*; #(
   parameter int unsigned SAMPLE_BYTES = 128,
   parameter int unsigned REGION_BYTES = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          word_take,
   input  wire logic [63:0]   sample_word,
   input  wire logic          word_last,
   input  wire logic [63:0]   reuse_interval_ns,
   output logic               push,
   output pcc_event_type      push_event
);

   localparam int unsigned SAMPLE_WORDS = SAMPLE_BYTES / 8;
   localparam int unsigned REGION_WORDS = REGION_BYTES / 8;
   localparam int unsigned POS_W        = $clog2(SAMPLE_WORDS + 1);
   localparam int unsigned IDX_W        = POS_W + 3;

   function automatic logic is_printable(input logic [7:0] b);
      return (b >= 8'h20 && b <= 8'h7e) || b == 8'h09 || b == 8'h0a || b == 8'h0d;
   endfunction

   function automatic logic is_prologue(input logic [63:0] w);
      return (w[7:0] == 8'h55 && w[15:8] == 8'h48)
          || (w[31:0] == 32'hfa1e0ff3)
          || (w[7:0] == 8'h48 && w[15:8] == 8'h83);
   endfunction

   function automatic logic is_pointer_like(input logic [63:0] w);
      return w[63:48] == 16'h0000 || w[63:48] == 16'hffff || w[63:56] == 8'h7f;
   endfunction

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               zero_ff, zero_in;
   logic               same_ff, same_in;
   logic [7:0]         fill_ff, fill_in;
   logic [PRINT_W-1:0] print_ff, print_in;
   logic               prol_ff, prol_in;
   logic [PTR_W-1:0]   ptr_ff, ptr_in;

   logic               absorb;
   logic               complete;
   logic               zero_abs, same_abs, prol_abs;
   logic [7:0]         fill_abs;
   logic [PRINT_W-1:0] print_abs;
   logic [PTR_W-1:0]   ptr_abs;
   logic [3:0]         print_word;
   logic [7:0]         cur_byte;
   logic [IDX_W-1:0]   byte_idx;

   assign absorb   = pos_ff < POS_W'(SAMPLE_WORDS);
   assign complete = pos_ff >= POS_W'(SAMPLE_WORDS - 1);

   // Fold the current word into the event trackers: eight byte compares and a count.
   always_comb begin
      fill_abs   = (pos_ff == '0) ? sample_word[7:0] : fill_ff;
      prol_abs   = (pos_ff == '0) ? is_prologue(sample_word) : prol_ff;
      zero_abs   = zero_ff;
      same_abs   = same_ff;
      print_word = '0;
      cur_byte   = '0;
      byte_idx   = '0;
      for (int i = 0; i < 8; i++) begin
         cur_byte = sample_word[8*i +: 8];
         byte_idx = {pos_ff, 3'b000} + IDX_W'(i);
         if (cur_byte != 8'h00) zero_abs = 1'b0;
         if (cur_byte != fill_abs) same_abs = 1'b0;
         if (byte_idx < IDX_W'(REGION_BYTES) && is_printable(cur_byte)) begin
            print_word = print_word + 4'd1;
         end
      end
      print_abs = print_ff + PRINT_W'(print_word);
      ptr_abs   = ptr_ff;
      if (pos_ff < POS_W'(REGION_WORDS) && is_pointer_like(sample_word)) begin
         ptr_abs = ptr_ff + PTR_W'(1);
      end
   end

   // Next tracker state: the last word of an event returns all trackers to reset.
   always_comb begin
      pos_in   = pos_ff;
      zero_in  = zero_ff;
      same_in  = same_ff;
      fill_in  = fill_ff;
      print_in = print_ff;
      prol_in  = prol_ff;
      ptr_in   = ptr_ff;
      if (word_take) begin
         if (word_last) begin
            pos_in   = '0;
            zero_in  = 1'b1;
            same_in  = 1'b1;
            fill_in  = '0;
            print_in = '0;
            prol_in  = 1'b0;
            ptr_in   = '0;
         end else if (absorb) begin
            pos_in   = pos_ff + POS_W'(1);
            zero_in  = zero_abs;
            same_in  = same_abs;
            fill_in  = fill_abs;
            print_in = print_abs;
            prol_in  = prol_abs;
            ptr_in   = ptr_abs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         zero_ff  <= 1'b1;
         same_ff  <= 1'b1;
         fill_ff  <= '0;
         print_ff <= '0;
         prol_ff  <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         zero_ff  <= zero_in;
         same_ff  <= same_in;
         fill_ff  <= fill_in;
         print_ff <= print_in;
         prol_ff  <= prol_in;
         ptr_ff   <= ptr_in;
      end
   end

   // A complete event is handed on; a short one is dropped silently.
   assign push = word_take && word_last && complete;

   always_comb begin
      push_event.zero_page = absorb ? zero_abs  : zero_ff;
      push_event.same_page = absorb ? same_abs  : same_ff;
      push_event.fill      = absorb ? fill_abs  : fill_ff;
      push_event.printable = absorb ? print_abs : print_ff;
      push_event.prologue  = absorb ? prol_abs  : prol_ff;
      push_event.pointers  = absorb ? ptr_abs   : ptr_ff;
      push_event.interval  = reuse_interval_ns;
   end

endmodule

`default_nettype wire

>>> rtl/pcc_queue.sv
`default_nettype none

module pcc_queue import pcc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  pcc_event_type      push_event,
   output logic               full,
   output logic               head_valid,
   output pcc_event_type      head_event,
   input  wire logic          pop
);

   // Two-entry queue of event summaries between the front and the back.
   pcc_event_type entry_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_event = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pcc_back.sv
`default_nettype none

module pcc_back import pcc_pkg::*; #(
   parameter int unsigned REGION_BYTES = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  pcc_cfg_type        cfg,
   input  wire logic          head_valid,
   input  pcc_event_type      head_event,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [2:0]         rsp_page_class,
   output logic               rsp_zero_page,
   output logic [7:0]         rsp_fill_value,
   output logic               rsp_thrashing,
   output logic [63:0]        rsp_class_total,
   output logic [63:0]        rsp_thrash_total
);

   localparam int unsigned CLS_IDX_W = $clog2(CLASS_NUM);

   logic [63:0]   class_count_ff [CLASS_NUM];
   logic [63:0]   class_count_in;
   logic [63:0]   thrash_count_ff, thrash_count_in;
   logic          valid_ff, valid_in;
   pcc_class_type class_ff, cls;
   logic          zero_ff, thrash_ff, thrash;
   logic [7:0]    fill_ff;
   logic [63:0]   class_total_ff, thrash_total_ff;
   logic [15:0]   print_scaled, print_needed;
   logic          is_text, is_pointer;
   logic [63:0]   cur_count;

   // Take the head event when the output register is empty or being drained.
   assign pop = head_valid && (!valid_ff || !rsp_stall);

   // Text test without a divider: floor(p*100/R) >= m exactly when p*100 >= m*R.
   assign print_scaled = 16'(head_event.printable) * 16'd100;
   assign print_needed = 16'(cfg.ascii_percent_min) * 16'(REGION_BYTES);
   assign is_text      = print_scaled >= print_needed;
   assign is_pointer   = head_event.pointers >= PTR_W'(cfg.pointer_words_min);

   // Class in priority order.
   always_comb begin
      priority if (head_event.zero_page) cls = CLASS_ZERO;
      else if (head_event.same_page)     cls = CLASS_SAME;
      else if (is_text)                  cls = CLASS_TEXT;
      else if (head_event.prologue)      cls = CLASS_CODE;
      else if (is_pointer)               cls = CLASS_POINTER;
      else                               cls = CLASS_BINARY;
   end

   // Saturating counter updates and the next output-valid state.
   always_comb begin
      thrash          = head_event.interval < cfg.thrash_limit_ns;
      cur_count       = class_count_ff[CLS_IDX_W'(cls)];
      class_count_in  = (&cur_count) ? cur_count : cur_count + 64'd1;
      thrash_count_in = thrash_count_ff;
      if (thrash && !(&thrash_count_ff)) thrash_count_in = thrash_count_ff + 64'd1;
      valid_in = valid_ff;
      if (pop) valid_in = 1'b1;
      else if (!rsp_stall) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         thrash_count_ff <= '0;
         for (int i = 0; i < CLASS_NUM; i++) class_count_ff[i] <= '0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            thrash_count_ff               <= thrash_count_in;
            class_count_ff[CLS_IDX_W'(cls)] <= class_count_in;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (pop) begin
         class_ff        <= cls;
         zero_ff         <= head_event.zero_page;
         fill_ff         <= head_event.fill;
         thrash_ff       <= thrash;
         class_total_ff  <= class_count_in;
         thrash_total_ff <= thrash_count_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_page_class     = class_ff;
   assign rsp_zero_page      = zero_ff;
   assign rsp_fill_value     = fill_ff;
   assign rsp_thrashing      = thrash_ff;
   assign rsp_class_total    = class_total_ff;
   assign rsp_thrash_total   = thrash_total_ff;

endmodule

`default_nettype wire

>>> rtl/page_content_classifier.sv
// After an event's last word its summary enters the queue, then the result register.
// Throughput: one word per cycle; an event of SAMPLE_BYTES/8 words yields one result.
// The two-entry event queue stalls the input only while it is full.
// Reset (synchronous, active high) clears event trackers, counters and the queue,
// and loads the configuration registers with their default values.
`default_nettype none

module page_content_classifier import pcc_pkg::*; #(
   parameter int unsigned SAMPLE_BYTES = 128,
   parameter int unsigned REGION_BYTES = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [63:0]  req_sample_word,
   input  wire logic         req_word_last,
   input  wire logic [63:0]  req_reuse_interval_ns,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_page_class,
   output logic              rsp_zero_page,
   output logic [7:0]        rsp_fill_value,
   output logic              rsp_thrashing,
   output logic [63:0]       rsp_class_total,
   output logic [63:0]       rsp_thrash_total,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_data
);

   pcc_cfg_type   cfg_ff, cfg_in;
   logic          word_take;
   logic          push, full, head_valid, pop;
   pcc_event_type push_event, head_event;

   // Configuration writes are always accepted and registered; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ASCII_PERCENT_MIN: cfg_in.ascii_percent_min = csr_data[6:0];
            CSR_POINTER_WORDS_MIN: cfg_in.pointer_words_min = csr_data[2:0];
            CSR_THRASH_LIMIT_NS:   cfg_in.thrash_limit_ns   = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ascii_percent_min <= 7'd70;
         cfg_ff.pointer_words_min <= 3'd3;
         cfg_ff.thrash_limit_ns   <= 64'd5000000000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input transfers stall only while the event queue is full.
   assign req_stall = full;
   assign word_take = req_valid && !req_stall;

   pcc_front #(
      .SAMPLE_BYTES (SAMPLE_BYTES),
      .REGION_BYTES (REGION_BYTES)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .word_take         (word_take),
      .sample_word       (req_sample_word),
      .word_last         (req_word_last),
      .reuse_interval_ns (req_reuse_interval_ns),
      .push              (push),
      .push_event        (push_event)
   );

   pcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .full       (full),
      .head_valid (head_valid),
      .head_event (head_event),
      .pop        (pop)
   );

   pcc_back #(
      .REGION_BYTES (REGION_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .head_valid         (head_valid),
      .head_event         (head_event),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_page_class     (rsp_page_class),
      .rsp_zero_page      (rsp_zero_page),
      .rsp_fill_value     (rsp_fill_value),
      .rsp_thrashing      (rsp_thrashing),
      .rsp_class_total    (rsp_class_total),
      .rsp_thrash_total   (rsp_thrash_total)
   );

endmodule

`default_nettype wire
